// ===== design/apra_pkg.sv =====
// Shared types, codes and defaults for the aligned page run allocator.
`timescale 1ns / 1ps

package apra_pkg;

    localparam int DEF_NUM_ENTRIES = 512;
    localparam int DEF_PAGE_SHIFT  = 21;

    localparam int ADDR_W   = 48;
    localparam int BUS_W    = 32;
    localparam int FIRST_W  = 9;
    localparam int COUNT_W  = 10;
    localparam int STATUS_W = 3;

    localparam logic [ADDR_W-1:0] WINDOW_BASE_RST = 48'h0001_0000_0000;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO_LEN   = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NO_SPACE   = 3'd3,
        ST_NOT_MAPPED = 3'd4
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic [FIRST_W-1:0] first_entry;
        logic [ADDR_W-1:0]  mapped_addr;
        status_t            status;
    } res_t;

endpackage

// ===== design/apra_table.sv =====
// Entry table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module apra_table #(
    parameter int DEPTH = 512,
    parameter int ENT_W = 13
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ENT_W-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ENT_W-1:0]         wr_data
);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/apra_seq.sv =====
// Sequencer that sizes, searches, fills and clears page runs one entry at a time.
`timescale 1ns / 1ps

module apra_seq #(
    parameter int NUM_ENTRIES = 512,
    parameter int PAGE_SHIFT  = 21,
    parameter int IDX_W       = $clog2(NUM_ENTRIES),
    parameter int ENT_W       = 2 + 32 - PAGE_SHIFT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_op,
    input  logic [31:0]               in_region_addr,
    input  logic [31:0]               in_length,
    input  logic [47:0]               in_unmap_addr,
    input  logic [47:0]               window_base,
    output logic [IDX_W-1:0]          tbl_raddr,
    input  logic [ENT_W-1:0]          tbl_rdata,
    output logic                      tbl_we,
    output logic [IDX_W-1:0]          tbl_waddr,
    output logic [ENT_W-1:0]          tbl_wdata,
    output logic                      res_valid,
    input  logic                      res_take,
    output apra_pkg::res_t            res
);

    import apra_pkg::*;

    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam int XW    = CNT_W + 2;
    localparam int PPN_W = BUS_W - PAGE_SHIFT;
    localparam logic [33:0] PG_M1 = 34'((1 << PAGE_SHIFT) - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_STRIDE, S_WIN, S_SCAN_RD, S_SCAN_CHK,
        S_FILL, S_UN_RD, S_UN_CHK, S_DONE
    } state_t;

    state_t                state_reg;
    logic                  op_reg;
    logic [31:0]           bus_reg;
    logic [31:0]           len_reg;
    logic [47:0]           uaddr_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [XW-1:0]         first_reg;
    logic [XW-1:0]         end_reg;
    logic [XW-1:0]         stride_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [PAGE_SHIFT-1:0] offset_reg;
    logic [PPN_W-1:0]      ppn_reg;
    res_t                  res_reg;

    logic [33:0]           size_sum;
    logic [33:0]           count_raw;
    logic [47:0]           diff;
    logic [47:0]           idx_raw;
    logic                  ent_present;
    logic                  ent_last;
    logic                  at_run_end;
    logic                  at_table_end;

    assign size_sum  = {2'b00, bus_reg & PG_M1[31:0]} + {2'b00, len_reg} + PG_M1;
    assign count_raw = size_sum >> PAGE_SHIFT;
    assign diff      = uaddr_reg - window_base;
    assign idx_raw   = diff >> PAGE_SHIFT;

    assign ent_present  = tbl_rdata[ENT_W-1];
    assign ent_last     = tbl_rdata[ENT_W-2];
    assign at_run_end   = ((XW'(pos_reg) + XW'(1)) == end_reg);
    assign at_table_end = (pos_reg == IDX_W'(NUM_ENTRIES - 1));

    // The table is addressed by the position register in every state.
    always_comb
    begin
        tbl_raddr = pos_reg;
        tbl_waddr = pos_reg;
        tbl_we    = (state_reg == S_CLEAR) || (state_reg == S_FILL) ||
                    ((state_reg == S_UN_CHK) && ent_present);
        tbl_wdata = '0;
        if (state_reg == S_FILL)
        begin
            tbl_wdata = {1'b1, at_run_end, ppn_reg};
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pos_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    pos_reg <= pos_reg + IDX_W'(1);
                    if (at_table_end)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= in_op;
                        bus_reg   <= in_region_addr;
                        len_reg   <= in_length;
                        uaddr_reg <= in_unmap_addr;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    res_reg <= '{entry_count: '0, first_entry: '0,
                                 mapped_addr: '0, status: ST_OK};
                    if (op_reg == OP_MAP)
                    begin
                        offset_reg <= bus_reg[PAGE_SHIFT-1:0];
                        ppn_reg    <= PPN_W'(bus_reg >> PAGE_SHIFT);
                        stride_reg <= XW'(1);
                        count_reg  <= CNT_W'(count_raw);
                        if (len_reg == 32'd0)
                        begin
                            res_reg.status <= ST_ZERO_LEN;
                            state_reg      <= S_DONE;
                        end
                        else if (count_raw >= 34'(NUM_ENTRIES))
                        begin
                            res_reg.status <= ST_TOO_LARGE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_STRIDE;
                        end
                    end
                    else
                    begin
                        first_reg <= XW'(idx_raw);
                        pos_reg   <= IDX_W'(idx_raw);
                        count_reg <= '0;
                        if (idx_raw >= 48'(NUM_ENTRIES))
                        begin
                            res_reg.status <= ST_NOT_MAPPED;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_UN_RD;
                        end
                    end
                end
                S_STRIDE:
                begin
                    // Shift the stride up until it covers the page count.
                    if (stride_reg < XW'(count_reg))
                    begin
                        stride_reg <= stride_reg << 1;
                    end
                    else
                    begin
                        first_reg <= '0;
                        state_reg <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    end_reg <= first_reg + XW'(count_reg);
                    pos_reg <= IDX_W'(first_reg);
                    if ((first_reg + XW'(count_reg)) > XW'(NUM_ENTRIES))
                    begin
                        res_reg.status <= ST_NO_SPACE;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (ent_present)
                    begin
                        first_reg <= first_reg + stride_reg;
                        state_reg <= S_WIN;
                    end
                    else if (at_run_end)
                    begin
                        pos_reg   <= IDX_W'(first_reg);
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + IDX_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_FILL:
                begin
                    ppn_reg <= ppn_reg + PPN_W'(1);
                    pos_reg <= pos_reg + IDX_W'(1);
                    if (at_run_end)
                    begin
                        res_reg.mapped_addr <= window_base +
                            ((48'(first_reg) << PAGE_SHIFT) | 48'(offset_reg));
                        res_reg.first_entry <= FIRST_W'(first_reg);
                        res_reg.entry_count <= COUNT_W'(count_reg);
                        state_reg           <= S_DONE;
                    end
                end
                S_UN_RD:
                begin
                    state_reg <= S_UN_CHK;
                end
                S_UN_CHK:
                begin
                    if (!ent_present)
                    begin
                        // A missing first entry means the address was never mapped.
                        if (count_reg == '0)
                        begin
                            res_reg.status <= ST_NOT_MAPPED;
                        end
                        else
                        begin
                            res_reg.first_entry <= FIRST_W'(first_reg);
                            res_reg.entry_count <= COUNT_W'(count_reg);
                        end
                        state_reg <= S_DONE;
                    end
                    else if (ent_last || at_table_end)
                    begin
                        res_reg.first_entry <= FIRST_W'(first_reg);
                        res_reg.entry_count <= COUNT_W'(count_reg) + COUNT_W'(1);
                        state_reg           <= S_DONE;
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        pos_reg   <= pos_reg + IDX_W'(1);
                        state_reg <= S_UN_RD;
                    end
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/aligned_page_run_allocator_unit.sv =====
// Top level of the aligned page run allocator: ports, window base register, output stage.
//
//  Channel  Direction  Carries
//  s_*      in         s_tuser: op; s_tdata: region_addr, length, unmap_addr
//  m_*      out        m_tdata: status, mapped_addr, first_entry, entry_count
//  cfg_*    in         window_base write
//
// One request at a time. A map decodes the request, sizes the stride by doubling, tries
// windows in turn, probes each entry of a window with a table read and a check, and fills
// the run entry by entry; an unmap decodes and then reads and checks one entry after another.
// Zero length, oversize and out-of-table requests end after the decode. The registered table
// read is why each probe has a read state and a check state.
// After reset a clearing pass over all NUM_ENTRIES entries runs before s_tready rises.
// A result is copied into the output register once it is taken and waits there while the next request is accepted.
`timescale 1ns / 1ps

module aligned_page_run_allocator_unit #(
    parameter int NUM_ENTRIES = apra_pkg::DEF_NUM_ENTRIES,
    parameter int PAGE_SHIFT  = apra_pkg::DEF_PAGE_SHIFT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // region_addr[31:0], length[63:32], unmap_addr[111:64]
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], mapped_addr[50:3], first_entry[59:51], entry_count[69:60], zero pad
    output logic [71:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata
);

    import apra_pkg::*;

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int ENT_W = 2 + BUS_W - PAGE_SHIFT;

    logic [ADDR_W-1:0] window_base_reg;
    logic              out_full_reg;
    res_t              out_reg;

    logic [IDX_W-1:0]  tbl_raddr;
    logic [ENT_W-1:0]  tbl_rdata;
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;
    logic [ENT_W-1:0]  tbl_wdata;
    logic              res_valid;
    logic              res_take;
    res_t              res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= WINDOW_BASE_RST;
        end
        else if (cfg_we)
        begin
            window_base_reg <= cfg_wdata;
        end
    end

    assign res_take = res_valid && (!out_full_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_full_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {2'b00, out_reg.entry_count, out_reg.first_entry,
                       out_reg.mapped_addr, out_reg.status};

    apra_seq #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .IDX_W       (IDX_W),
        .ENT_W       (ENT_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser),
        .in_region_addr (s_tdata[31:0]),
        .in_length      (s_tdata[63:32]),
        .in_unmap_addr  (s_tdata[111:64]),
        .window_base    (window_base_reg),
        .tbl_raddr      (tbl_raddr),
        .tbl_rdata      (tbl_rdata),
        .tbl_we         (tbl_we),
        .tbl_waddr      (tbl_waddr),
        .tbl_wdata      (tbl_wdata),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res)
    );

    apra_table #(
        .DEPTH (NUM_ENTRIES),
        .ENT_W (ENT_W)
    ) u_table (
        .clk     (clk),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata)
    );

endmodule

// ===== tb/sv/aligned_page_run_allocator_unit_test.sv =====
// Self-checking testbench for the aligned page run allocator: stream stimulus, scoreboard.
`timescale 1ns / 1ps

module aligned_page_run_allocator_unit_test;

    import apra_pkg::*;

    localparam int NE = DEF_NUM_ENTRIES;
    localparam int PS = DEF_PAGE_SHIFT;
    localparam logic [ADDR_W-1:0] PAGE_BYTES = 48'd1 << PS;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 2 * NE + 64;
    localparam int PHASE_ITEMS = 108;

    typedef struct packed {
        logic              op;
        logic [BUS_W-1:0]  region_addr;
        logic [BUS_W-1:0]  length;
        logic [ADDR_W-1:0] unmap_addr;
    } request_t;

    typedef struct {
        int first;
        int count;
    } run_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;     // region_addr[31:0], length[63:32], unmap_addr[111:64]
    logic         s_tuser = 1'b0;   // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;          // status, mapped_addr, first_entry, entry_count, pad
    logic         cfg_we = 1'b0;
    logic [47:0]  cfg_wdata = '0;

    // Mirror of the entry table; page numbers never reach the outputs, so only
    // the present and last-of-run marks are kept.
    logic              entry_used [NE];
    logic              entry_tail [NE];
    logic [ADDR_W-1:0] window_base_q = WINDOW_BASE_RST;

    request_t request_fifo [$];
    res_t     expected_results [$];
    run_t     live_runs [$];
    request_t cur_req;

    int  queued_count = 0;
    int  accepted_count = 0;
    int  fault_count = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  recv_hold = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;

    aligned_page_run_allocator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    // Applies one request to the mirrored table and returns the result it gives.
    function automatic res_t apply_request(input request_t rq);
        res_t              r;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] diff;
        logic [63:0]       span;
        int                pages;
        int                stride;
        int                cand;
        int                found;
        int                idx;
        int                cnt;
        int                i;
        bit                busy;
        bit                tail;
        r = '0;
        r.status = ST_OK;
        if (rq.op == OP_MAP)
        begin
            offset = 48'(rq.region_addr) & (PAGE_BYTES - 1);
            span = (64'(offset) + 64'(rq.length) + 64'(PAGE_BYTES) - 1) >> PS;
            if (rq.length == 0)
                r.status = ST_ZERO_LEN;
            else if (span >= 64'(NE))
                r.status = ST_TOO_LARGE;
            else
            begin
                pages = int'(span);
                stride = 1;
                while (stride < pages)
                    stride = stride << 1;
                found = -1;
                for (cand = 0; cand + pages <= NE && found < 0; cand += stride)
                begin
                    busy = 1'b0;
                    for (i = cand; i < cand + pages; i++)
                        busy |= entry_used[i];
                    if (!busy)
                        found = cand;
                end
                if (found < 0)
                    r.status = ST_NO_SPACE;
                else
                begin
                    for (i = found; i < found + pages; i++)
                    begin
                        entry_used[i] = 1'b1;
                        entry_tail[i] = (i == found + pages - 1);
                    end
                    r.mapped_addr = window_base_q + (48'(found) << PS) + offset;
                    r.first_entry = FIRST_W'(found);
                    r.entry_count = COUNT_W'(pages);
                    live_runs.push_back('{first: found, count: pages});
                end
            end
        end
        else
        begin
            diff = rq.unmap_addr - window_base_q;
            if ((diff >> PS) >= 48'(NE) || !entry_used[int'(diff >> PS)])
                r.status = ST_NOT_MAPPED;
            else
            begin
                idx = int'(diff >> PS);
                cnt = 0;
                // A run ends at its last mark, at a hole, or at the end of the table.
                for (i = idx; i < NE && entry_used[i]; i++)
                begin
                    tail = entry_tail[i];
                    entry_used[i] = 1'b0;
                    entry_tail[i] = 1'b0;
                    cnt++;
                    if (tail)
                        break;
                end
                r.first_entry = FIRST_W'(idx);
                r.entry_count = COUNT_W'(cnt);
            end
        end
        return r;
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_request(cur_req));
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (request_fifo.size() != 0)
                begin
                    cur_req = request_fifo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_req.op;
                    s_tdata <= {cur_req.unmap_addr, cur_req.length, cur_req.region_addr};
                    send_gap <= send_idle_on ? $urandom_range(0, 19) : 0;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor; each beat is checked against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        int   stall;
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_hold <= 0;
        end
        else
        begin
            stall = recv_hold;
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata[69:0]);
                if (expected_results.size() == 0)
                    note_fault($sformatf("unexpected beat: status %0d addr %h first %0d count %0d",
                                         got.status, got.mapped_addr, got.first_entry,
                                         got.entry_count));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.mapped_addr !== want.mapped_addr ||
                        got.first_entry !== want.first_entry ||
                        got.entry_count !== want.entry_count)
                        note_fault($sformatf({"mismatch: expected status %0d addr %h first %0d ",
                                              "count %0d, got status %0d addr %h first %0d ",
                                              "count %0d"},
                                             want.status, want.mapped_addr, want.first_entry,
                                             want.entry_count, got.status, got.mapped_addr,
                                             got.first_entry, got.entry_count));
                end
                stall = recv_idle_on ? $urandom_range(0, 19) : 0;
            end
            else if (m_tvalid && stall != 0)
                stall = stall - 1;
            recv_hold <= stall;
            m_tready <= (stall == 0);
        end
    end

    task automatic push_request(input request_t rq);
        while (request_fifo.size() >= 2)
            @(posedge clk);
        request_fifo.push_back(rq);
        queued_count++;
    endtask

    task automatic queue_map(input logic [31:0] bus, input logic [31:0] len);
        request_t rq;
        rq.op = OP_MAP;
        rq.region_addr = bus;
        rq.length = len;
        rq.unmap_addr = 48'({$urandom, $urandom});
        push_request(rq);
    endtask

    task automatic queue_unmap(input logic [47:0] addr);
        request_t rq;
        rq.op = OP_UNMAP;
        rq.region_addr = $urandom;
        rq.length = $urandom;
        rq.unmap_addr = addr;
        push_request(rq);
    endtask

    // Mostly maps of modest size and unmaps of live runs, with some noise.
    task automatic queue_random_item();
        int   sel;
        int   pages;
        int   pick;
        int   k;
        run_t run;
        sel = $urandom_range(0, 99);
        if (sel >= 45 && sel < 80 && live_runs.size() != 0)
        begin
            pick = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[pick];
            k = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, run.count - 1);
            // Cutting a run in the middle leaves a head without a last mark.
            if (k == 0)
                live_runs.delete(pick);
            else
                live_runs[pick].count = k;
            queue_unmap(window_base_q + (48'(run.first + k) << PS) +
                        48'($urandom_range(0, (1 << PS) - 1)));
        end
        else if (sel >= 80 && sel < 86)
            queue_unmap(48'({$urandom, $urandom}));
        else if (sel >= 86 && sel < 90)
            queue_map($urandom, 32'd0);
        else if (sel >= 90 && sel < 95)
            queue_map($urandom, $urandom);
        else if (sel >= 95)
            queue_unmap(window_base_q + (48'($urandom_range(0, NE + 3)) << PS) +
                        48'($urandom_range(0, (1 << PS) - 1)));
        else
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
                pages = $urandom_range(1, 4);
            else if (k < 95)
                pages = $urandom_range(5, 32);
            else
                pages = $urandom_range(33, NE - 1);
            queue_map($urandom, $urandom_range(1, pages << PS));
        end
    endtask

    task automatic wait_quiet();
        while (accepted_count != queued_count || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [47:0] bases [6];
        int          ph;
        int          n;
        for (n = 0; n < NE; n++)
        begin
            entry_used[n] = 1'b0;
            entry_tail[n] = 1'b0;
        end
        bases[0] = 48'h0000_0000_0000;
        bases[1] = 48'hFFFF_FFFF_FFFF;
        bases[2] = 48'({$urandom, $urandom});
        bases[3] = 48'hFFFF_FFE0_0123;
        bases[4] = WINDOW_BASE_RST;
        bases[5] = 48'({$urandom, $urandom});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // The block clears its table before it takes the first beat.
        while (!s_tready)
            @(posedge clk);

        // Directed part, run with the reset window base.
        queue_map(32'hFFFF_FFFF, 32'd0);
        queue_map(32'h0000_0000, 32'd1);
        queue_map(32'h001F_FFFF, 32'd2);
        queue_map(32'hFFE0_1000, 32'h0030_0000);
        queue_map(32'h0000_0000, 32'hFFFF_FFFF);
        queue_map(32'h0010_0000, 32'((NE - 1) << PS));
        queue_map(32'h0000_0000, 32'((NE - 1) << PS));
        queue_unmap(window_base_q);
        queue_unmap(window_base_q);
        queue_unmap(window_base_q + 3 * PAGE_BYTES + 5);
        queue_unmap(window_base_q + 2 * PAGE_BYTES);
        queue_unmap(window_base_q - 1);
        queue_unmap(window_base_q + 48'(NE) * PAGE_BYTES);
        queue_unmap(window_base_q + 5 * PAGE_BYTES - 1);
        queue_map(32'h0000_0000, 32'((NE - 1) << PS));
        queue_map(32'h0000_0000, 32'd1);
        queue_map(32'h0000_0000, 32'd1);
        queue_unmap(window_base_q + 48'(NE - 1) * PAGE_BYTES);
        queue_unmap(window_base_q + 300 * PAGE_BYTES);
        queue_unmap(window_base_q);
        queue_map(32'hFFFF_FFFF, 32'd1);
        queue_unmap(48'hFFFF_FFFF_FFFF);

        for (ph = 0; ph < 6; ph++)
        begin
            wait_quiet();
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= bases[ph];
            window_base_q = bases[ph];
            @(posedge clk);
            cfg_we <= 1'b0;
            send_idle_on = (ph == 5) ? 1'($urandom_range(0, 1)) : (ph % 4 == 0 || ph == 2);
            recv_idle_on = (ph == 5) ? 1'($urandom_range(0, 1)) : (ph % 4 == 0 || ph == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_random_item();
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            note_fault($sformatf("%0d results never arrived", expected_results.size()));
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
